FILE: rtl/rph_pkg.sv
// Shared constants for the RGB patch histogram block.
`default_nettype none

package rph_pkg;

  // Pixel and result field widths.
  localparam int PIX_W     = 8;
  localparam int CH_W      = 2;
  localparam int BIN_OUT_W = 4;
  localparam int FRAC_W    = 17;
  localparam int FRAC_BITS = 16;

  // Quotient bit counter for the fraction divider.
  localparam int STEP_W = $clog2(FRAC_W);

  // Channel codes, in emission order.
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_RED   = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/rph_bank.sv
// Bin counter memory of one colour channel with read-modify-write update.
`default_nettype none

module rph_bank #(
  parameter int BINS  = 16,
  parameter int CNT_W = 17
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     upd,
  input  wire logic [$clog2(BINS)-1:0]  upd_addr,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(BINS)-1:0]  rd_addr,
  output logic      [CNT_W-1:0]         rd_count
);

  localparam int BIN_W = $clog2(BINS);

  logic [CNT_W-1:0] mem [BINS];
  logic [BINS-1:0]  valid;

  logic [BIN_W-1:0] addr;
  logic [CNT_W-1:0] rd_q;
  logic             vld_q;

  logic             s1_upd;
  logic [BIN_W-1:0] s1_addr;

  logic             fwd_en;
  logic [BIN_W-1:0] fwd_addr;
  logic [CNT_W-1:0] fwd_data;

  logic [CNT_W-1:0] cnt_old;
  logic [CNT_W-1:0] cnt_new;

  // One shared read port: the emit read and the pixel update never coincide.
  assign addr = rd_en ? rd_addr : upd_addr;

  // An entry that has not been written since it was last read out counts as zero.
  // The write of the previous pixel lands on the same edge as this read, so it is forwarded.
  always_comb begin
    if (fwd_en && (fwd_addr == s1_addr)) begin
      cnt_old = fwd_data;
    end else if (vld_q) begin
      cnt_old = rd_q;
    end else begin
      cnt_old = '0;
    end
    cnt_new = cnt_old + CNT_W'(1);
  end

  assign rd_count = vld_q ? rd_q : '0;

  // Memory array with a registered read.
  always_ff @(posedge clk) begin
    if (upd || rd_en) begin
      rd_q  <= mem[addr];
      vld_q <= valid[addr];
    end
    if (s1_upd) begin
      mem[s1_addr] <= cnt_new;
    end
  end

  // Pipeline address and forwarding data.
  always_ff @(posedge clk) begin
    s1_addr <= upd_addr;
    if (s1_upd) begin
      fwd_addr <= s1_addr;
      fwd_data <= cnt_new;
    end
  end

  // Entry valid bits; an emit read clears the entry it reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      s1_upd <= 1'b0;
      fwd_en <= 1'b0;
    end else begin
      s1_upd <= upd;
      if (s1_upd) begin
        valid[s1_addr] <= 1'b1;
        fwd_en         <= 1'b1;
      end
      if (rd_en) begin
        valid[rd_addr] <= 1'b0;
        fwd_en         <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rph_div.sv
// Radix-2 restoring divider giving floor(count * 2^16 / pixels), one quotient bit a cycle.
`default_nettype none

module rph_div #(
  parameter int CNT_W = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [CNT_W-1:0]          count,
  input  wire logic [CNT_W-1:0]          pixels,
  output logic                           busy,
  output logic [rph_pkg::FRAC_W-1:0]     quotient
);

  import rph_pkg::*;

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              first;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // The count never exceeds the divisor, so the first step compares it unshifted.
  always_comb begin
    trial = first ? {1'b0, rem} : {rem, 1'b0};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  // Operand and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= count;
      dvs      <= pixels;
      first    <= 1'b1;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      first    <= 1'b0;
      quotient <= {quotient[FRAC_W-2:0], ge};
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(FRAC_W - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - STEP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgb_patch_histogram.sv
// Pixels are taken one per cycle while a patch accumulates; at MAX_PIXELS counting stops.
// After the last pixel the input stalls through a drain step and then, for each of the 3 * BINS
// results, a bank read, a divider load, the divider's quotient bits and a step to see it finish,
// and a move into the output register, which waits while the output is stalled.
// The final result may wait in the output register while the next patch is accepted.
// Synchronous reset empties the banks through their valid bits at once and clears the pixel count,
// the saturation flag, the control state and the output register.
`default_nettype none

module rgb_patch_histogram #(
  parameter int BINS       = 16,
  parameter int MAX_PIXELS = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rph_pkg::PIX_W-1:0]       blue,
  input  wire logic [rph_pkg::PIX_W-1:0]       green,
  input  wire logic [rph_pkg::PIX_W-1:0]       red,
  input  wire logic                            last_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [rph_pkg::CH_W-1:0]        channel,
  output logic      [rph_pkg::BIN_OUT_W-1:0]   bin,
  output logic      [rph_pkg::FRAC_W-1:0]      fraction,
  output logic                                 saturated,
  output logic                                 last_bin
);

  import rph_pkg::*;

  localparam int BIN_W = $clog2(BINS);
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  typedef enum logic [2:0] {
    S_ACC,
    S_DRAIN,
    S_READ,
    S_START,
    S_DIV,
    S_PUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] pixel_count;
  logic             sat_flag;
  logic [CH_W-1:0]  ch_idx;
  logic [BIN_W-1:0] bin_idx;

  logic             in_take;
  logic             full;
  logic             upd;
  logic             last_entry;
  logic             out_free;

  logic [CNT_W-1:0] cnt_blue;
  logic [CNT_W-1:0] cnt_green;
  logic [CNT_W-1:0] cnt_red;
  logic [CNT_W-1:0] cnt_sel;

  logic              div_busy;
  logic [FRAC_W-1:0] div_q;

  // Handshake and control decode.
  assign in_stall   = (state != S_ACC);
  assign in_take    = in_valid && !in_stall;
  assign full       = (pixel_count == CNT_W'(MAX_PIXELS));
  assign upd        = in_take && !full;
  assign last_entry = (ch_idx == CH_RED) && (bin_idx == BIN_W'(BINS - 1));
  assign out_free   = !out_valid || !out_stall;

  // The bin is the top bits of the channel value.
  rph_bank #(.BINS(BINS), .CNT_W(CNT_W)) u_bank_blue (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .upd_addr (blue[PIX_W-1 -: BIN_W]),
    .rd_en    ((state == S_READ) && (ch_idx == CH_BLUE)),
    .rd_addr  (bin_idx),
    .rd_count (cnt_blue)
  );

  rph_bank #(.BINS(BINS), .CNT_W(CNT_W)) u_bank_green (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .upd_addr (green[PIX_W-1 -: BIN_W]),
    .rd_en    ((state == S_READ) && (ch_idx == CH_GREEN)),
    .rd_addr  (bin_idx),
    .rd_count (cnt_green)
  );

  rph_bank #(.BINS(BINS), .CNT_W(CNT_W)) u_bank_red (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .upd_addr (red[PIX_W-1 -: BIN_W]),
    .rd_en    ((state == S_READ) && (ch_idx == CH_RED)),
    .rd_addr  (bin_idx),
    .rd_count (cnt_red)
  );

  // Select the count of the channel being emitted.
  always_comb begin
    case (ch_idx)
      CH_BLUE:  cnt_sel = cnt_blue;
      CH_GREEN: cnt_sel = cnt_green;
      CH_RED:   cnt_sel = cnt_red;
      default:  cnt_sel = '0;
    endcase
  end

  rph_div #(.CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .count    (cnt_sel),
    .pixels   (pixel_count),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Sequencer, pixel counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_ACC;
      pixel_count <= '0;
      sat_flag    <= 1'b0;
      ch_idx      <= CH_BLUE;
      bin_idx     <= '0;
      out_valid   <= 1'b0;
      channel     <= CH_BLUE;
      bin         <= '0;
      fraction    <= '0;
      saturated   <= 1'b0;
      last_bin    <= 1'b0;
    end else begin
      if ((state == S_PUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          if (in_take) begin
            if (full) begin
              sat_flag <= 1'b1;
            end else begin
              pixel_count <= pixel_count + CNT_W'(1);
            end
            if (last_pixel) begin
              ch_idx  <= CH_BLUE;
              bin_idx <= '0;
              state   <= S_DRAIN;
            end
          end
        end
        // Let the last pixel's bank write land before reading out.
        S_DRAIN: state <= S_READ;
        S_READ:  state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (!div_busy) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            channel   <= ch_idx;
            bin       <= BIN_OUT_W'(bin_idx);
            fraction  <= (pixel_count == '0) ? '0 : div_q;
            saturated <= sat_flag;
            last_bin  <= last_entry;
            if (last_entry) begin
              pixel_count <= '0;
              sat_flag    <= 1'b0;
              state       <= S_ACC;
            end else begin
              if (bin_idx == BIN_W'(BINS - 1)) begin
                bin_idx <= '0;
                ch_idx  <= (ch_idx == CH_BLUE) ? CH_GREEN : CH_RED;
              end else begin
                bin_idx <= bin_idx + BIN_W'(1);
              end
              state <= S_READ;
            end
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the RGB patch histogram block.
`timescale 1ns / 1ps

module tb;

  localparam int BINS       = 16;
  localparam int MAX_PIXELS = 65536;
  localparam int BIN_WIDTH  = 256 / BINS;
  localparam int TOTAL_BINS = 3 * BINS;
  localparam int FRAC_ONE   = 1 << rph_pkg::FRAC_BITS;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1100;

  // One histogram result as seen on the output port.
  typedef struct packed {
    logic [rph_pkg::CH_W-1:0]      channel;
    logic [rph_pkg::BIN_OUT_W-1:0] bin;
    logic [rph_pkg::FRAC_W-1:0]    fraction;
    logic                          saturated;
    logic                          last_bin;
  } bin_result_t;

  // Tracks the bin counts of the open patch and holds the histogram results still due.
  class patch_hist_tracker;
    int unsigned bin_count [TOTAL_BINS];
    int unsigned pixel_total;
    bit          sat_seen;
    logic [rph_pkg::CH_W-1:0] ch_code [3];
    bin_result_t pending [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned pixels;
    int unsigned patches;
    int unsigned sat_patches;

    function new();
      ch_code = '{rph_pkg::CH_BLUE, rph_pkg::CH_GREEN, rph_pkg::CH_RED};
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (bin_count[k]) bin_count[k] = 0;
      pixel_total = 0;
      sat_seen = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Accepted pixel transaction: update the counts and, on the last pixel, queue the histogram.
    function void take_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic lp);
      bin_result_t      e;
      longint unsigned  q;
      pixels++;
      if (pixel_total >= MAX_PIXELS) begin
        // A full patch ignores further pixels but remembers that they came.
        sat_seen = 1;
      end else begin
        bin_count[b / BIN_WIDTH]++;
        bin_count[BINS + g / BIN_WIDTH]++;
        bin_count[2 * BINS + r / BIN_WIDTH]++;
        pixel_total++;
      end
      if (!lp) return;
      for (int k = 0; k < TOTAL_BINS; k++) begin
        q = 0;
        if (pixel_total != 0) q = (longint'(bin_count[k]) * FRAC_ONE) / pixel_total;
        if (q > FRAC_ONE) q = FRAC_ONE;
        e.channel   = ch_code[k / BINS];
        e.bin       = rph_pkg::BIN_OUT_W'(k % BINS);
        e.fraction  = q[rph_pkg::FRAC_W-1:0];
        e.saturated = sat_seen;
        e.last_bin  = (k == TOTAL_BINS - 1);
        pending.push_back(e);
      end
      patches++;
      if (sat_seen) sat_patches++;
      clear_counts();
    endfunction

    // Accepted result transaction: compare with the oldest histogram entry still due.
    function void compare_result(bin_result_t got);
      bin_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result ch %0d bin %0d frac %0d sat %0b last %0b",
                         got.channel, got.bin, got.fraction, got.saturated, got.last_bin));
        return;
      end
      want = pending.pop_front();
      if (got.channel !== want.channel || got.bin !== want.bin ||
          got.fraction !== want.fraction || got.saturated !== want.saturated ||
          got.last_bin !== want.last_bin)
        report($sformatf({"expected ch %0d bin %0d frac %0d sat %0b last %0b, ",
                          "got ch %0d bin %0d frac %0d sat %0b last %0b"},
                         want.channel, want.bin, want.fraction, want.saturated, want.last_bin,
                         got.channel, got.bin, got.fraction, got.saturated, got.last_bin));
    endfunction

    function void flush_leftovers();
      foreach (pending[k])
        report($sformatf("missing result ch %0d bin %0d frac %0d",
                         pending[k].channel, pending[k].bin, pending[k].fraction));
      pending.delete();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [rph_pkg::PIX_W-1:0] blue = '0;
  logic [rph_pkg::PIX_W-1:0] green = '0;
  logic [rph_pkg::PIX_W-1:0] red = '0;
  logic last_pixel = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [rph_pkg::CH_W-1:0]      channel;
  logic [rph_pkg::BIN_OUT_W-1:0] bin;
  logic [rph_pkg::FRAC_W-1:0]    fraction;
  logic saturated;
  logic last_bin;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned drain_wait;

  patch_hist_tracker tracker = new();

  rgb_patch_histogram #(
    .BINS       (BINS),
    .MAX_PIXELS (MAX_PIXELS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel    (channel),
    .bin        (bin),
    .fraction   (fraction),
    .saturated  (saturated),
    .last_bin   (last_bin)
  );

  always #5 clk = ~clk;

  // Output side: check each accepted result, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        tracker.compare_result({channel, bin, fraction, saturated, last_bin});
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one pixel after an optional random gap and waits until the transaction completes.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic lp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    blue       <= b;
    green      <= g;
    red        <= r;
    last_pixel <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_pixel(b, g, r, lp);
  endtask

  // Channel value: uniform, an extreme, or the edge of a random bin.
  function automatic logic [7:0] pick_level(int unsigned style);
    case (style)
      0: return 8'($urandom_range(255));
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(BINS - 1) * BIN_WIDTH +
                         ($urandom_range(1) ? BIN_WIDTH - 1 : 0));
    endcase
  endfunction

  // Extremes, bin edges, single-pixel patches and a patch that fills one bin per channel.
  task automatic run_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd15, 8'd16, 8'd31, 1'b0);
    send_pixel(8'd240, 8'd239, 8'd128, 1'b0);
    send_pixel(8'd127, 8'd128, 8'd255, 1'b1);
    repeat (4) send_pixel(8'd100, 8'd200, 8'd50, 1'b0);
    send_pixel(8'd111, 8'd207, 8'd63, 1'b1);
    send_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hF0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h80, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h7F, 1'b0);
    send_pixel(8'h01, 8'hFE, 8'h10, 1'b0);
    send_pixel(8'hFE, 8'h01, 8'hEF, 1'b0);
    send_pixel(8'h3C, 8'hC3, 8'h99, 1'b1);
  endtask

  // Patches of random length; the style is chosen per patch so some fill few bins.
  task automatic run_random(input int unsigned n_pix);
    int unsigned left;
    int unsigned len;
    int unsigned style;
    left = n_pix;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (len > left) len = left;
      style = $urandom_range(2);
      for (int i = 1; i <= len; i++)
        send_pixel(pick_level(style), pick_level(style), pick_level(style), i == len);
      left -= len;
    end
  endtask

  // Main sequence: reset, directed patches, then the three idling phases.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 19;
    recv_stall_pct = 50;
    run_directed();
    run_random(85);
    send_idle_pct  = 50;
    recv_stall_pct = 19;
    run_random(80);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(78);
    in_valid <= 1'b0;

    // Let the outstanding histograms drain, then watch for stray results.
    drain_wait = 0;
    while (tracker.pending.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.flush_leftovers();

    $display("Sent %0d pixels in %0d patches (%0d saturated); %0d histogram results checked.",
             tracker.pixels, tracker.patches, tracker.sat_patches, tracker.results_seen);
    $display("Mismatches: %0d", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rph_pkg.sv
rtl/rph_bank.sv
rtl/rph_div.sv
rtl/rgb_patch_histogram.sv
bench/tb.sv
